[hdl/knn_pkg.sv]
// shared types, codes and constant tables of the nearest-neighbor interpolator
`default_nettype none
package knn_pkg;

   localparam int DEF_MAX_POINTS    = 1024;
   localparam int DEF_MAX_NEIGHBORS = 16;

   localparam logic [4:0]  NC_RESET = 5'd4;
   localparam logic [15:0] DP_RESET = 16'd8192;

   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [2:0] ST_DONE   = 3'd0;
   localparam logic [2:0] ST_INTERP = 3'd1;
   localparam logic [2:0] ST_HIT    = 3'd2;
   localparam logic [2:0] ST_EMPTY  = 3'd3;
   localparam logic [2:0] ST_FULL   = 3'd4;

   localparam logic [1:0] CSR_NEIGHBOR = 2'd0;
   localparam logic [1:0] CSR_POWER    = 2'd1;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [23:0] u;
      logic signed [23:0] v;
      logic signed [23:0] w;
   } point_type;

   typedef struct packed {
      logic valid;
      logic less;
   } cell_link_type;

   typedef logic [31:0] root_tab_type [16];

   function automatic logic [31:0] isqrt64(logic [63:0] a);
      logic [31:0] r;
      logic [31:0] t;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (32'd1 << b);
         if ({32'd0, t} * {32'd0, t} <= a) r = t;
      end
      return r;
   endfunction

   // 2^(-2^-(j+1)) in Q0.32, each a floor of a square root of the one before
   function automatic root_tab_type make_roots();
      root_tab_type tab;
      tab[0] = isqrt64(64'h8000_0000_0000_0000);
      for (int j = 1; j < 16; j++) tab[j] = isqrt64({tab[j-1], 32'd0});
      return tab;
   endfunction

endpackage
`default_nettype wire

[hdl/knn_cell.sv]
// one slot of the sorted nearest-neighbor chain
`default_nettype none
module knn_cell #(
   parameter int IW = 10
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       clear,
   input  wire                       enable,
   input  wire                       insert,
   input  wire                       shift,
   input  wire  [63:0]               new_dist,
   input  wire  [IW-1:0]             new_idx,
   input  knn_pkg::cell_link_type    prev_link,
   input  wire  [63:0]               prev_dist,
   input  wire  [IW-1:0]             prev_idx,
   input  wire                       next_valid,
   input  wire  [63:0]               next_dist,
   input  wire  [IW-1:0]             next_idx,
   output knn_pkg::cell_link_type    link,
   output logic [63:0]               slot_dist,
   output logic [IW-1:0]             idx
);
   import knn_pkg::*;

   logic          valid_ff, valid_in;
   logic [63:0]   dist_ff, dist_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          less;

   // an empty slot counts as farther than anything; ties keep the older point
   assign less       = enable && (!valid_ff || new_dist < dist_ff);
   assign link.valid = valid_ff;
   assign link.less  = less;
   assign slot_dist  = dist_ff;
   assign idx        = idx_ff;

   always_comb begin
      valid_in = valid_ff;
      dist_in  = dist_ff;
      idx_in   = idx_ff;
      if (clear) begin
         valid_in = 1'b0;
      end else if (insert && less) begin
         if (prev_link.less) begin
            valid_in = prev_link.valid;
            dist_in  = prev_dist;
            idx_in   = prev_idx;
         end else begin
            valid_in = 1'b1;
            dist_in  = new_dist;
            idx_in   = new_idx;
         end
      end else if (shift) begin
         valid_in = next_valid;
         dist_in  = next_dist;
         idx_in   = next_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      idx_ff  <= idx_in;
   end

endmodule
`default_nettype wire

[hdl/knn_log2.sv]
// iterative log2 in Q6.16: six normalize steps, then sixteen squarings
`default_nettype none
module knn_log2 (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [63:0] value,
   output logic        done,
   output logic [21:0] result
);
   import knn_pkg::*;

   localparam logic [4:0] LAST_NORM = 5'd5;
   localparam logic [4:0] LAST_STEP = 5'd21;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  step_ff, step_in;
   logic [63:0] norm_ff, norm_in;
   logic [5:0]  msb_ff, msb_in;
   logic [31:0] m_ff, m_in;
   logic [15:0] frac_ff, frac_in;

   logic [6:0]  sh;
   logic [63:0] top_mask;
   logic        top_zero;
   logic [63:0] norm_nx;
   logic [63:0] prod;
   logic [32:0] sq;

   assign done   = done_ff;
   assign result = {msb_ff, frac_ff};

   always_comb begin
      sh       = 7'd32 >> step_ff[2:0];
      top_mask = ~({64{1'b1}} >> sh);
      top_zero = (norm_ff & top_mask) == 64'd0;
      norm_nx  = top_zero ? (norm_ff << sh) : norm_ff;
      prod     = {32'd0, m_ff} * {32'd0, m_ff};
      sq       = prod[63:31];

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      norm_in = norm_ff;
      msb_in  = msb_ff;
      m_in    = m_ff;
      frac_in = frac_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         norm_in = value;
         msb_in  = 6'd63;
         frac_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 5'd1;
         if (step_ff <= LAST_NORM) begin
            norm_in = norm_nx;
            if (top_zero) msb_in = msb_ff - sh[5:0];
            m_in = norm_nx[63:32];
         end else begin
            // a square at or above two gives a one bit and halves the mantissa
            if (sq[32]) begin
               frac_in = {frac_ff[14:0], 1'b1};
               m_in    = sq[32:1];
            end else begin
               frac_in = {frac_ff[14:0], 1'b0};
               m_in    = sq[31:0];
            end
            if (step_ff == LAST_STEP) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      norm_ff <= norm_in;
      msb_ff  <= msb_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
   end

endmodule
`default_nettype wire

[hdl/knn_exp2.sv]
// iterative 2^-e in Q1.31: one root multiply per fraction bit, then a shift
`default_nettype none
module knn_exp2 (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [24:0] expo,
   output logic        done,
   output logic [31:0] weight
);
   import knn_pkg::*;

   localparam root_tab_type ROOTS = make_roots();
   localparam logic [4:0] SHIFT_STEP = 5'd16;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  step_ff, step_in;
   logic [15:0] f_ff, f_in;
   logic [8:0]  n_ff, n_in;
   logic [31:0] r_ff, r_in;
   logic [31:0] w_ff, w_in;
   logic [63:0] prod;

   assign done   = done_ff;
   assign weight = w_ff;

   always_comb begin
      prod    = {32'd0, r_ff} * {32'd0, ROOTS[step_ff[3:0]]};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      f_in    = f_ff;
      n_in    = n_ff;
      r_in    = r_ff;
      w_in    = w_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         f_in    = expo[15:0];
         n_in    = expo[24:16];
         r_in    = 32'h8000_0000;
      end else if (busy_ff) begin
         step_in = step_ff + 5'd1;
         if (step_ff == SHIFT_STEP) begin
            w_in    = (n_ff >= 9'd32) ? 32'd0 : (r_ff >> n_ff[4:0]);
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (f_ff[~step_ff[3:0]]) begin
            r_in = prod[63:32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      f_ff    <= f_in;
      n_ff    <= n_in;
      r_ff    <= r_in;
      w_ff    <= w_in;
   end

endmodule
`default_nettype wire

[hdl/knn_div.sv]
// restoring unsigned 64-bit divider, one quotient bit a cycle
`default_nettype none
module knn_div (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [63:0] num,
   input  wire  [63:0] den,
   output logic        done,
   output logic [63:0] quo
);
   import knn_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  step_ff, step_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [64:0] rem2;
   logic [64:0] diff;

   assign done = done_ff;
   assign quo  = q_ff;

   always_comb begin
      rem2    = {rem_ff, q_ff[63]};
      diff    = rem2 - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         step_in = step_ff + 6'd1;
         if (!diff[64]) begin
            rem_in = diff[63:0];
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = rem2[63:0];
            q_in   = {q_ff[62:0], 1'b0};
         end
         if (step_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

endmodule
`default_nettype wire

[hdl/knn_idw_interpolator.sv]
// top level: point table, sorted neighbor chain and weighted-mean sequencer
//
// Commands enter on start/req_* and are taken when start is high and busy low.
// Each command gives exactly one result, shown on rsp_* for one cycle with
// rsp_valid high; the receiver cannot stall it.
// Load, clear, an unknown action, a load into a full table and a query on an
// empty table answer in the cycle after the transfer, and the next command may
// follow at once.
// A query streams every stored point out of the table at one read a cycle
// through a three-stage distance pipe into the neighbor chain, which holds
// the k best points in order. An exact hit then answers from the S_HIT
// state with the nearest point. Otherwise each neighbor takes one log2, one
// exp2 and the power, multiply and accumulate states, plus one log2 for the
// nearest, and three divisions close the query.
// Configuration writes on csr_* are always ready and meant for idle times.
// Reset empties the table and sets neighbor_count to 4 and distance_power
// to 2.0; table contents are not cleared.
`default_nettype none
module knn_idw_interpolator #(
   parameter int MAX_POINTS    = knn_pkg::DEF_MAX_POINTS,
   parameter int MAX_NEIGHBORS = knn_pkg::DEF_MAX_NEIGHBORS
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire  [1:0]         req_action,
   input  wire  signed [31:0] req_coord_x,
   input  wire  signed [31:0] req_coord_y,
   input  wire  signed [31:0] req_coord_z,
   input  wire  signed [23:0] req_point_u,
   input  wire  signed [23:0] req_point_v,
   input  wire  signed [23:0] req_point_w,
   output logic               rsp_valid,
   output logic signed [23:0] rsp_interp_u,
   output logic signed [23:0] rsp_interp_v,
   output logic signed [23:0] rsp_interp_w,
   output logic [2:0]         rsp_status,
   output logic [4:0]         rsp_neighbors_used,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire  [1:0]         csr_index,
   input  wire  [15:0]        csr_data
);
   import knn_pkg::*;

   localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int KW = $clog2(MAX_NEIGHBORS + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_POINTS);

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_SCAN = 11'b000_0000_0010,
      S_HIT  = 11'b000_0000_0100,
      S_LOG0 = 11'b000_0000_1000,
      S_LOGI = 11'b000_0001_0000,
      S_POW  = 11'b000_0010_0000,
      S_EXP  = 11'b000_0100_0000,
      S_MUL  = 11'b000_1000_0000,
      S_ACC  = 11'b001_0000_0000,
      S_DIV  = 11'b010_0000_0000,
      S_SPARE = 11'b100_0000_0000
   } state_type;

   point_type mem [MAX_POINTS];

   state_type   state_ff, state_in;
   logic [4:0]  nc_ff, nc_in;
   logic [15:0] dp_ff, dp_in;
   logic [CW-1:0] count_ff, count_in;
   logic [KW-1:0] kk_ff, kk_in;
   logic [KW-1:0] t_ff, t_in;
   logic signed [31:0] qx_ff, qy_ff, qz_ff;
   logic [CW-1:0] issue_ff, issue_in;
   logic        p1_v_ff, p1_v_in, p2_v_ff, p3_v_ff;
   logic [IW-1:0] p1_idx_ff, p2_idx_ff, p3_idx_ff;
   logic [63:0] sqx_ff, sqy_ff, sqz_ff, sum_ff;
   point_type   rd_ff;
   logic [IW-1:0] rd_addr;
   logic [21:0] l0_ff, l0_in;
   logic [21:0] dd_ff, dd_in;
   logic [24:0] e_ff, e_in;
   logic [31:0] w_ff, w_in;
   logic signed [63:0] mu_ff, mv_ff, mw_ff;
   logic signed [63:0] su_ff, su_in, sv_ff, sv_in, sw_ff, sw_in;
   logic [63:0] ws_ff, ws_in;
   logic [1:0]  comp_ff, comp_in;
   logic [23:0] ru_ff, ru_in, rv_ff, rv_in;
   logic        log_start_ff, log_start_in;
   logic        exp_start_ff, exp_start_in;
   logic        div_start_ff, div_start_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_u_ff, rsp_u_in, rsp_v_ff, rsp_v_in, rsp_w_ff, rsp_w_in;
   logic [2:0]  rsp_st_ff, rsp_st_in;
   logic [4:0]  rsp_nu_ff, rsp_nu_in;

   logic        accept;
   logic        query_go;
   logic        cell_shift;
   logic        cell_insert;
   int          kk_calc;

   cell_link_type cl [MAX_NEIGHBORS];
   logic [63:0]   cd [MAX_NEIGHBORS];
   logic [IW-1:0] ci [MAX_NEIGHBORS];

   logic        log_done, exp_done, div_done;
   logic [21:0] log_res;
   logic [31:0] exp_w;
   logic [63:0] div_q;
   logic signed [63:0] div_sel;
   logic        div_neg;
   logic [63:0] div_mag;
   logic [63:0] div_num;
   logic [23:0] div_sat;

   logic signed [32:0] dx, dy, dz;
   logic [31:0] adx, ady, adz;
   logic [64:0] s1, s2;
   logic [63:0] t1;

   assign accept    = start && !busy;
   assign busy      = state_ff != S_IDLE;
   assign csr_ready = 1'b1;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_interp_u       = rsp_u_ff;
   assign rsp_interp_v       = rsp_v_ff;
   assign rsp_interp_w       = rsp_w_ff;
   assign rsp_status         = rsp_st_ff;
   assign rsp_neighbors_used = rsp_nu_ff;

   // neighbor chain
   genvar g;
   generate
      for (g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
         cell_link_type pl;
         logic [63:0]   pd;
         logic [IW-1:0] pi;
         logic          nv;
         logic [63:0]   nd;
         logic [IW-1:0] ni;
         if (g == 0) begin : g_head
            assign pl = '{valid: 1'b0, less: 1'b0};
            assign pd = '0;
            assign pi = '0;
         end else begin : g_body
            assign pl = cl[g-1];
            assign pd = cd[g-1];
            assign pi = ci[g-1];
         end
         if (g == MAX_NEIGHBORS - 1) begin : g_tail
            assign nv = 1'b0;
            assign nd = '1;
            assign ni = '0;
         end else begin : g_mid
            assign nv = cl[g+1].valid;
            assign nd = cd[g+1];
            assign ni = ci[g+1];
         end
         knn_cell #(.IW(IW)) u_cell (
            .clock      (clock),
            .reset      (reset),
            .clear      (query_go),
            .enable     (KW'(g) < kk_ff),
            .insert     (cell_insert),
            .shift      (cell_shift),
            .new_dist   (sum_ff),
            .new_idx    (p3_idx_ff),
            .prev_link  (pl),
            .prev_dist  (pd),
            .prev_idx   (pi),
            .next_valid (nv),
            .next_dist  (nd),
            .next_idx   (ni),
            .link       (cl[g]),
            .slot_dist  (cd[g]),
            .idx        (ci[g])
         );
      end
   endgenerate

   knn_log2 u_log2 (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start_ff),
      .value  (cd[0]),
      .done   (log_done),
      .result (log_res)
   );

   knn_exp2 u_exp2 (
      .clock  (clock),
      .reset  (reset),
      .start  (exp_start_ff),
      .expo   (e_ff),
      .done   (exp_done),
      .weight (exp_w)
   );

   knn_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num),
      .den   (ws_ff),
      .done  (div_done),
      .quo   (div_q)
   );

   // distance pipe
   always_comb begin
      dx  = {rd_ff.x[31], rd_ff.x} - {qx_ff[31], qx_ff};
      dy  = {rd_ff.y[31], rd_ff.y} - {qy_ff[31], qy_ff};
      dz  = {rd_ff.z[31], rd_ff.z} - {qz_ff[31], qz_ff};
      adx = dx[32] ? 32'(-dx) : dx[31:0];
      ady = dy[32] ? 32'(-dy) : dy[31:0];
      adz = dz[32] ? 32'(-dz) : dz[31:0];
      s1  = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      t1  = s1[64] ? {64{1'b1}} : s1[63:0];
      s2  = {1'b0, t1} + {1'b0, sqz_ff};
   end

   always_comb begin
      kk_calc = (nc_ff == 5'd0) ? 1 : int'(nc_ff);
      if (kk_calc > MAX_NEIGHBORS) kk_calc = MAX_NEIGHBORS;
      if (kk_calc > int'(count_ff)) kk_calc = int'(count_ff);
   end

   always_comb begin
      case (comp_ff)
         2'd0:    div_sel = su_ff;
         2'd1:    div_sel = sv_ff;
         default: div_sel = sw_ff;
      endcase
      div_neg = div_sel[63];
      div_mag = div_neg ? 64'(-div_sel) : 64'(div_sel);
      div_num = div_mag + (ws_ff >> 1);
      if (div_neg) begin
         div_sat = (div_q > 64'h80_0000) ? 24'h80_0000 : 24'(0 - div_q[23:0]);
      end else begin
         div_sat = (div_q > 64'h7F_FFFF) ? 24'h7F_FFFF : div_q[23:0];
      end
   end

   assign rd_addr = (state_ff == S_SCAN && issue_ff < count_ff) ? issue_ff[IW-1:0] : ci[0];
   assign cell_insert = (state_ff == S_SCAN) && p3_v_ff;

   always_comb begin
      state_in     = state_ff;
      nc_in        = nc_ff;
      dp_in        = dp_ff;
      count_in     = count_ff;
      kk_in        = kk_ff;
      t_in         = t_ff;
      issue_in     = issue_ff;
      p1_v_in      = 1'b0;
      l0_in        = l0_ff;
      dd_in        = dd_ff;
      e_in         = e_ff;
      w_in         = w_ff;
      su_in        = su_ff;
      sv_in        = sv_ff;
      sw_in        = sw_ff;
      ws_in        = ws_ff;
      comp_in      = comp_ff;
      ru_in        = ru_ff;
      rv_in        = rv_ff;
      log_start_in = 1'b0;
      exp_start_in = 1'b0;
      div_start_in = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_u_in     = '0;
      rsp_v_in     = '0;
      rsp_w_in     = '0;
      rsp_st_in    = ST_DONE;
      rsp_nu_in    = '0;
      query_go     = 1'b0;
      cell_shift   = 1'b0;

      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_NEIGHBOR) nc_in = csr_data[4:0];
         else if (csr_index == CSR_POWER) dp_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= FULL_COUNT) rsp_st_in = ST_FULL;
                     else count_in = count_ff + CW'(1);
                  end
                  ACT_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     count_in     = '0;
                  end
                  ACT_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_st_in    = ST_EMPTY;
                     end else begin
                        query_go = 1'b1;
                        kk_in    = KW'(kk_calc);
                        issue_in = '0;
                        state_in = S_SCAN;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_SCAN: begin
            if (issue_ff < count_ff) begin
               p1_v_in  = 1'b1;
               issue_in = issue_ff + CW'(1);
            end else if (!p1_v_ff && !p2_v_ff && !p3_v_ff) begin
               su_in = '0;
               sv_in = '0;
               sw_in = '0;
               ws_in = '0;
               t_in  = '0;
               if (cd[0] == 64'd0) begin
                  state_in = S_HIT;
               end else begin
                  log_start_in = 1'b1;
                  state_in     = S_LOG0;
               end
            end
         end
         S_HIT: begin
            rsp_valid_in = 1'b1;
            rsp_u_in     = rd_ff.u;
            rsp_v_in     = rd_ff.v;
            rsp_w_in     = rd_ff.w;
            rsp_st_in    = ST_HIT;
            rsp_nu_in    = 5'd1;
            state_in     = S_IDLE;
         end
         S_LOG0: begin
            if (log_done) begin
               l0_in        = log_res;
               log_start_in = 1'b1;
               state_in     = S_LOGI;
            end
         end
         S_LOGI: begin
            if (log_done) begin
               dd_in    = log_res - l0_ff;
               state_in = S_POW;
            end
         end
         S_POW: begin
            e_in         = 25'(({16'd0, dd_ff} * {22'd0, dp_ff}) >> 13);
            exp_start_in = 1'b1;
            state_in     = S_EXP;
         end
         S_EXP: begin
            if (exp_done) begin
               w_in     = exp_w;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            su_in      = su_ff + mu_ff;
            sv_in      = sv_ff + mv_ff;
            sw_in      = sw_ff + mw_ff;
            ws_in      = ws_ff + {32'd0, w_ff};
            cell_shift = 1'b1;
            t_in       = t_ff + KW'(1);
            if (t_ff + KW'(1) == kk_ff) begin
               comp_in      = 2'd0;
               div_start_in = 1'b1;
               state_in     = S_DIV;
            end else begin
               log_start_in = 1'b1;
               state_in     = S_LOGI;
            end
         end
         S_DIV: begin
            if (div_done) begin
               case (comp_ff)
                  2'd0: begin
                     ru_in        = div_sat;
                     comp_in      = 2'd1;
                     div_start_in = 1'b1;
                  end
                  2'd1: begin
                     rv_in        = div_sat;
                     comp_in      = 2'd2;
                     div_start_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_u_in     = ru_ff;
                     rsp_v_in     = rv_ff;
                     rsp_w_in     = div_sat;
                     rsp_st_in    = ST_INTERP;
                     rsp_nu_in    = 5'(kk_ff);
                     state_in     = S_IDLE;
                  end
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nc_ff        <= NC_RESET;
         dp_ff        <= DP_RESET;
         count_ff     <= '0;
         kk_ff        <= '0;
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         p3_v_ff      <= 1'b0;
         log_start_ff <= 1'b0;
         exp_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nc_ff        <= nc_in;
         dp_ff        <= dp_in;
         count_ff     <= count_in;
         kk_ff        <= kk_in;
         p1_v_ff      <= p1_v_in;
         p2_v_ff      <= p1_v_ff;
         p3_v_ff      <= p2_v_ff;
         log_start_ff <= log_start_in;
         exp_start_ff <= exp_start_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         qx_ff <= req_coord_x;
         qy_ff <= req_coord_y;
         qz_ff <= req_coord_z;
      end
      t_ff      <= t_in;
      issue_ff  <= issue_in;
      p1_idx_ff <= issue_ff[IW-1:0];
      p2_idx_ff <= p1_idx_ff;
      p3_idx_ff <= p2_idx_ff;
      sqx_ff    <= {32'd0, adx} * {32'd0, adx};
      sqy_ff    <= {32'd0, ady} * {32'd0, ady};
      sqz_ff    <= {32'd0, adz} * {32'd0, adz};
      sum_ff    <= s2[64] ? {64{1'b1}} : s2[63:0];
      l0_ff     <= l0_in;
      dd_ff     <= dd_in;
      e_ff      <= e_in;
      w_ff      <= w_in;
      mu_ff     <= 64'($signed({1'b0, w_ff}) * rd_ff.u);
      mv_ff     <= 64'($signed({1'b0, w_ff}) * rd_ff.v);
      mw_ff     <= 64'($signed({1'b0, w_ff}) * rd_ff.w);
      su_ff     <= su_in;
      sv_ff     <= sv_in;
      sw_ff     <= sw_in;
      ws_ff     <= ws_in;
      comp_ff   <= comp_in;
      ru_ff     <= ru_in;
      rv_ff     <= rv_in;
      rsp_u_ff  <= rsp_u_in;
      rsp_v_ff  <= rsp_v_in;
      rsp_w_ff  <= rsp_w_in;
      rsp_st_ff <= rsp_st_in;
      rsp_nu_ff <= rsp_nu_in;
   end

   // point table, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (accept && req_action == ACT_LOAD && count_ff < FULL_COUNT) begin
         mem[count_ff[IW-1:0]] <= '{x: req_coord_x, y: req_coord_y, z: req_coord_z,
                                    u: req_point_u, v: req_point_v, w: req_point_w};
      end
      rd_ff <= mem[rd_addr];
   end

endmodule
`default_nettype wire
